@@ rtl/core/tcgl_pkg.sv @@
// ----------------------------------------------------------------------------
// Glyph layout package
// Shared constants, code words and helper functions of the text code stream
// glyph layout block.
// ----------------------------------------------------------------------------
package tcgl_pkg;

	// Stream payload widths (whole bytes).
	localparam int S_DATA_W = 96;
	localparam int M_DATA_W = 136;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_LINE   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_DIRECT = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COUNT_SPACES = 3'd4;

	// Input kinds and result kinds.
	localparam logic KIND_START = 1'b0;
	localparam logic KIND_CODE  = 1'b1;
	localparam logic RK_GLYPH   = 1'b0;
	localparam logic RK_DONE    = 1'b1;

	// Control code words.
	localparam logic [15:0] CODE_NEWLINE   = 16'hFF00;
	localparam logic [15:0] CODE_SPACE     = 16'hFF01;
	localparam logic [15:0] CODE_SWALLOW_A = 16'hFF02;
	localparam logic [15:0] CODE_SWALLOW_B = 16'hFF03;
	localparam logic [15:0] CODE_GAP       = 16'hFF04;
	localparam logic [15:0] CODE_IGNORE_LO = 16'hFE00;
	localparam logic [15:0] CODE_END       = 16'hFFFF;

	// Scale reset value, 1.0 in Q4.12.
	localparam logic [15:0] SCALE_ONE = 16'h1000;

	// Advance widths in whole pixels for the codes that have a font entry.
	localparam int FONT_TABLE_SIZE = 108;
	localparam int FT_IDX_W = $clog2(FONT_TABLE_SIZE);
	localparam int WIDTH_ROM [FONT_TABLE_SIZE] = '{
		28, 14, 14, 28, 28, 28, 28, 14, 14, 14, 28, 22, 14, 20, 14, 28, 20, 20, 20, 20,
		20, 20, 20, 20, 20, 20, 14, 14, 28, 28, 28, 20, 28, 24, 24, 24, 24, 24, 24, 24,
		24, 14, 18, 26, 20, 28, 26, 24, 22, 24, 24, 20, 20, 24, 22, 28, 22, 22, 20, 14,
		28, 14, 28, 20, 28, 16, 16, 12, 16, 14, 14, 18, 18, 10, 12, 18, 10, 24, 18, 16,
		16, 16, 14, 14, 12, 18, 16, 20, 16, 16, 14, 28, 28, 28, 28, 28, 28, 28, 28, 28,
		28, 28, 28, 28, 28, 28, 28, 28
	};

	// Texture cell geometry: 18 by 18 cells of 14 pixels on a page.
	localparam int CELLS_PER_PAGE = 324;
	localparam int CELLS_PER_ROW  = 18;
	localparam int CELL_PIXELS    = 14;

	// Whole pixels times a Q4.12 scale, rounded half up to Q9.4.
	function automatic logic [12:0] scaled(input logic [4:0] n, input logic [15:0] s);
		logic [20:0] prod;
		prod = 21'(n) * 21'(s) + 21'd128;
		return prod[20:8];
	endfunction

	// Pen add that saturates at the top of the signed 16-bit range.
	function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
			input logic [12:0] d);
		logic [16:0] sum;
		sum = {a[15], a} + {4'b0, d};
		if (!sum[16] && sum[15])
			return 16'sh7FFF;
		return sum[15:0];
	endfunction

	// Texture page: code / 324 as ((code >> 2) * ceil(2^20 / 81)) >> 20.
	function automatic logic [7:0] page_of(input logic [15:0] code);
		logic [27:0] prod;
		prod = 28'(code[15:2]) * 28'd12946;
		return prod[27:20];
	endfunction

	// Palette lookup; index 0 and anything past the table give white.
	function automatic logic [31:0] palette_of(input logic [31:0] idx);
		logic [31:0] col;
		case (idx)
			32'd1:   col = 32'hFF20E0FF;
			32'd2:   col = 32'hFFFF2020;
			32'd3:   col = 32'hFF20FF20;
			32'd4:   col = 32'hFF606060;
			default: col = 32'hFFFFFFFF;
		endcase
		return col;
	endfunction

endpackage

@@ rtl/core/tcgl_cell_map.sv @@
// ----------------------------------------------------------------------------
// Glyph texture cell map
// Turns a code word and its texture page into the u/v corner of its cell.
// ----------------------------------------------------------------------------
module tcgl_cell_map (
	input  logic [15:0] code,
	input  logic [7:0]  page,
	output logic [7:0]  tex_u,
	output logic [7:0]  tex_v
);
	import tcgl_pkg::*;

	logic [15:0] page_base;
	logic [8:0]  page_cell;
	logic [14:0] row_prod;
	logic [4:0]  row;
	logic [4:0]  col;

	// Cell within the page, then row = cell / 18 by a reciprocal of 9 on cell / 2.
	assign page_base = 16'(16'(page) * 16'(CELLS_PER_PAGE));
	assign page_cell = 9'(code - page_base);
	assign row_prod  = 15'(page_cell[8:1]) * 15'd114;
	assign row       = row_prod[14:10];
	assign col       = 5'(page_cell - 9'(9'(row) * 9'(CELLS_PER_ROW)));

	assign tex_u = 8'(8'(col) * 8'(CELL_PIXELS));
	assign tex_v = 8'(8'(row) * 8'(CELL_PIXELS));

endmodule

@@ rtl/core/text_code_stream_glyph_layout.sv @@
// ----------------------------------------------------------------------------
// Text code stream glyph layout
// Each request passes the input register, then its result the output register.
// Throughput is one request per cycle while no result waits on a busy output
// register; a request that ends on the glyph limit gives a glyph and a done
// result and holds the output register until both go, which bounds the rate.
// Reset: arst_n clears the layout state to idle and the scales to 1.0.
// ----------------------------------------------------------------------------
module text_code_stream_glyph_layout (
	input  logic                          clk,
	input  logic                          arst_n,
	// Request stream. s_tdata fields from bit 0 up: code, start_x, start_y,
	// glyph_limit, color. s_tuser: kind (0 start, 1 code word).
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [tcgl_pkg::S_DATA_W-1:0] s_tdata,
	input  logic                          s_tuser,
	// Result stream. m_tdata fields from bit 0 up: pos_x, pos_y, tex_page,
	// tex_u, tex_v, argb, quad_w, quad_h, drawn_count. m_tuser: result_kind.
	// m_tlast: last result of the request.
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [tcgl_pkg::M_DATA_W-1:0] m_tdata,
	output logic                          m_tuser,
	output logic                          m_tlast,
	// Configuration write port.
	input  logic                          cfg_we,
	input  logic [tcgl_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [15:0]                   cfg_data
);
	import tcgl_pkg::*;

	// Configuration registers.
	logic [15:0] scale_x_q, scale_y_q, scale_line_q;
	logic        color_direct_q, count_spaces_q;

	// Layout state.
	logic signed [15:0] pen_x_q, pen_y_q, origin_x_q;
	logic               skip_q, limit_on_q, active_q;
	logic [15:0]        glyphs_q, remaining_q;
	logic [31:0]        held_color_q;

	// Input register. The texture page is worked out on the way in so that
	// the cell math in stage one starts from a registered page.
	logic               valid_s1;
	logic               kind_s1;
	logic [15:0]        code_s1;
	logic signed [15:0] start_x_s1, start_y_s1;
	logic [15:0]        limit_s1;
	logic [31:0]        color_s1;
	logic [7:0]         page_s1;

	// Output register and the done result that waits behind a glyph.
	logic                pend_q;
	logic                m_valid_q, m_kind_q, m_last_q;
	logic [M_DATA_W-1:0] m_data_q;

	logic s_take, m_take;
	assign s_take = s_tvalid && s_tready;
	assign m_take = m_valid_q && m_tready;

	// ------------------------------------------------------------------
	// Config. Host must write only while no request is in flight; not enforced.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_x_q      <= SCALE_ONE;
			scale_y_q      <= SCALE_ONE;
			scale_line_q   <= SCALE_ONE;
			color_direct_q <= 1'b0;
			count_spaces_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE_X:      scale_x_q      <= cfg_data;
				REG_SCALE_Y:      scale_y_q      <= cfg_data;
				REG_SCALE_LINE:   scale_line_q   <= cfg_data;
				REG_COLOR_DIRECT: color_direct_q <= cfg_data[0];
				REG_COUNT_SPACES: count_spaces_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stage one: decode the code word against the current layout state.
	// ------------------------------------------------------------------
	logic        is_start, live, act;
	logic        is_nl, is_sp, is_sw, is_gap, is_ign, is_end, is_gl;
	logic        limit_hit, sp_uses_limit, sp_done, gl_done;
	logic        has_result, out_free, advance;
	logic [4:0]  glyph_w;
	logic [12:0] adv14, adv28, adv_w, line_adv, quad_h13;
	logic signed [15:0] pen_sp, pen_gap, pen_gl, pen_y_nl;
	logic [15:0] glyphs_inc, remaining_dec;
	logic [31:0] argb;
	logic [7:0]  tex_u, tex_v;
	logic [M_DATA_W-1:0] glyph_data;

	tcgl_cell_map u_cell_map (
		.code  (code_s1),
		.page  (page_s1),
		.tex_u (tex_u),
		.tex_v (tex_v)
	);

	always_comb begin
		is_start = valid_s1 && (kind_s1 == KIND_START);
		live     = valid_s1 && (kind_s1 == KIND_CODE) && active_q;
		act      = live && !skip_q;

		is_nl  = act && (code_s1 == CODE_NEWLINE);
		is_sp  = act && (code_s1 == CODE_SPACE);
		is_sw  = act && (code_s1 == CODE_SWALLOW_A || code_s1 == CODE_SWALLOW_B);
		is_gap = act && (code_s1 == CODE_GAP);
		is_ign = act && (code_s1[15:4] == CODE_IGNORE_LO[15:4]);
		is_end = act && (code_s1 == CODE_END);
		is_gl  = act && !(is_nl || is_sp || is_sw || is_gap || is_ign || is_end);

		// The limit runs out when the count left is one, or already zero.
		limit_hit     = limit_on_q && (remaining_q <= 16'd1);
		remaining_dec = (remaining_q == '0) ? remaining_q : remaining_q - 16'd1;
		sp_uses_limit = is_sp && count_spaces_q && limit_on_q;
		sp_done       = is_sp && count_spaces_q && limit_hit;
		gl_done       = is_gl && limit_hit;

		has_result = sp_done || is_end || is_gl;
		out_free   = !m_valid_q || (m_tready && !pend_q);
		advance    = valid_s1 && (!has_result || out_free);

		glyph_w = (code_s1 < 16'(FONT_TABLE_SIZE)) ?
			5'(WIDTH_ROM[code_s1[FT_IDX_W-1:0]]) : 5'd0;

		adv14    = scaled(5'd14, scale_x_q);
		adv28    = scaled(5'd28, scale_x_q);
		adv_w    = scaled(glyph_w, scale_x_q);
		line_adv = scaled(5'd30, scale_line_q);
		quad_h13 = scaled(5'd28, scale_y_q);

		pen_sp   = sat_add(pen_x_q, adv14);
		pen_gap  = sat_add(pen_x_q, adv28);
		pen_gl   = sat_add(pen_x_q, adv_w);
		pen_y_nl = sat_add(pen_y_q, line_adv);

		glyphs_inc = (glyphs_q == 16'hFFFF) ? glyphs_q : glyphs_q + 16'd1;
		argb = color_direct_q ? held_color_q : palette_of(held_color_q);

		glyph_data = {glyphs_inc, 3'b0, quad_h13, 3'b0, adv28, argb,
			tex_v, tex_u, page_s1, pen_y_q, pen_x_q};
	end

	assign s_tready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			kind_s1    <= s_tuser;
			code_s1    <= s_tdata[15:0];
			start_x_s1 <= s_tdata[31:16];
			start_y_s1 <= s_tdata[47:32];
			limit_s1   <= s_tdata[63:48];
			color_s1   <= s_tdata[95:64];
			page_s1    <= page_of(s_tdata[15:0]);
		end
	end

	// Layout state advances once per request, as the request leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_x_q      <= '0;
			pen_y_q      <= '0;
			origin_x_q   <= '0;
			skip_q       <= 1'b0;
			glyphs_q     <= '0;
			remaining_q  <= '0;
			limit_on_q   <= 1'b0;
			held_color_q <= '0;
			active_q     <= 1'b0;
		end else if (advance) begin
			if (is_start) begin
				origin_x_q   <= start_x_s1;
				pen_x_q      <= start_x_s1;
				pen_y_q      <= start_y_s1;
				remaining_q  <= limit_s1;
				limit_on_q   <= (limit_s1 != '0);
				held_color_q <= color_s1;
				glyphs_q     <= '0;
				skip_q       <= 1'b0;
				active_q     <= 1'b1;
			end else if (live && skip_q) begin
				// The swallowed word does nothing else.
				skip_q <= 1'b0;
			end else begin
				if (is_nl) begin
					pen_x_q <= origin_x_q;
					pen_y_q <= pen_y_nl;
				end
				if (is_sp)
					pen_x_q <= pen_sp;
				if (sp_uses_limit)
					remaining_q <= remaining_dec;
				if (is_sw)
					skip_q <= 1'b1;
				if (is_gap)
					pen_x_q <= pen_gap;
				if (is_gl) begin
					glyphs_q <= glyphs_inc;
					pen_x_q  <= pen_gl;
					if (limit_on_q)
						remaining_q <= remaining_dec;
				end
				if (is_end || sp_done || gl_done)
					active_q <= 1'b0;
			end
		end
	end

	// ------------------------------------------------------------------
	// Output register. A glyph that uses up the limit leaves a done result
	// pending, which follows as soon as the glyph is taken.
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
			pend_q    <= 1'b0;
		end else if (advance && has_result) begin
			m_valid_q <= 1'b1;
			pend_q    <= gl_done;
		end else if (m_take) begin
			m_valid_q <= pend_q;
			pend_q    <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && has_result) begin
			if (is_gl) begin
				m_kind_q <= RK_GLYPH;
				m_last_q <= !gl_done;
				m_data_q <= glyph_data;
			end else begin
				// Done result: a count only when the end code closed the message.
				m_kind_q <= RK_DONE;
				m_last_q <= 1'b1;
				m_data_q <= {(is_end ? glyphs_q : 16'd0), {(M_DATA_W-16){1'b0}}};
			end
		end else if (m_take && pend_q) begin
			m_kind_q <= RK_DONE;
			m_last_q <= 1'b1;
			m_data_q <= '0;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;
	assign m_tdata  = m_data_q;

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_pend_has_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> m_valid_q)
		else $error("pending done without a glyph in the output register");

	a_pend_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		pend_q |-> (m_kind_q == RK_GLYPH && !m_last_q))
		else $error("pending done behind a result that is not an open glyph");

	a_limit_left: assert property (@(posedge clk) disable iff (!arst_n)
		(active_q && limit_on_q) |-> (remaining_q != '0))
		else $error("message still active with its glyph limit used up");

	a_glyph_counted: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && m_kind_q == RK_GLYPH) |-> (m_data_q[M_DATA_W-1 -: 16] != '0))
		else $error("glyph result with a zero drawn count");

endmodule

@@ tb/tcgl_layout_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph layout checker
// Watches the request, result and register ports of the glyph layout block.
// It keeps its own pen, limit and register state, works out the quads and done
// results of each accepted request and compares every accepted result with
// the oldest one still owed.
// ----------------------------------------------------------------------------
module tcgl_layout_checker (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	input  logic [tcgl_pkg::S_DATA_W-1:0]    s_tdata,
	input  logic                             s_tuser,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	input  logic [tcgl_pkg::M_DATA_W-1:0]    m_tdata,
	input  logic                             m_tuser,
	input  logic                             m_tlast,
	input  logic                             cfg_we,
	input  logic [tcgl_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [15:0]                      cfg_data,
	output int                               mismatches,
	output int                               pending,
	output int                               glyph_count,
	output int                               done_count
);
	import tcgl_pkg::*;

	localparam logic [15:0] IGNORE_HI = CODE_IGNORE_LO + 16'd15;

	// Pen advance in whole pixels of each code that has a font entry.
	localparam int GLYPH_ADVANCE [FONT_TABLE_SIZE] = '{
		28, 14, 14, 28, 28, 28, 28, 14, 14, 14, 28, 22, 14, 20, 14, 28, 20, 20, 20, 20,
		20, 20, 20, 20, 20, 20, 14, 14, 28, 28, 28, 20, 28, 24, 24, 24, 24, 24, 24, 24,
		24, 14, 18, 26, 20, 28, 26, 24, 22, 24, 24, 20, 20, 24, 22, 28, 22, 22, 20, 14,
		28, 14, 28, 20, 28, 16, 16, 12, 16, 14, 14, 18, 18, 10, 12, 18, 10, 24, 18, 16,
		16, 16, 14, 14, 12, 18, 16, 20, 16, 16, 14, 28, 28, 28, 28, 28, 28, 28, 28, 28,
		28, 28, 28, 28, 28, 28, 28, 28
	};

	localparam logic [31:0] TINTS [5] = '{
		32'hFFFFFFFF, 32'hFF20E0FF, 32'hFFFF2020, 32'hFF20FF20, 32'hFF606060
	};

	typedef struct {
		logic        kind;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [7:0]  page;
		logic [7:0]  u;
		logic [7:0]  v;
		logic [31:0] argb;
		logic [15:0] quad_w;
		logic [15:0] quad_h;
		logic [15:0] count;
		logic        last;
	} layout_result_t;

	layout_result_t owed_results[$];

	logic [15:0] sc_x, sc_y, sc_line;
	logic        direct_color, spaces_count;
	int          pen_x, pen_y, org_x;
	int          drawn, limit_left;
	bit          swallow_next, limit_on, in_message;
	logic [31:0] msg_color;
	int          n_checked;

	function automatic int scale_px(input int n, input logic [15:0] s);
		return (n * int'(s) + 128) >>> 8;
	endfunction

	function automatic int pen_step(input int a, input int d);
		int r;
		r = a + d;
		if (r > 32767)
			r = 32767;
		if (r < -32768)
			r = -32768;
		return r;
	endfunction

	// True when a running limit has just been used up.
	function automatic bit spend_limit();
		if (!limit_on)
			return 1'b0;
		if (limit_left > 0)
			limit_left--;
		return limit_left == 0;
	endfunction

	task automatic note_failure(input string msg);
		mismatches++;
		$display("ERROR at %0t: %s", $realtime, msg);
	endtask

	task automatic compare_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got)
			note_failure($sformatf("result %0d %s: expected 0x%0h, got 0x%0h",
				n_checked, name, want, got));
	endtask

	task automatic lay_out_request(input logic kind, input logic [15:0] code,
			input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] lim,
			input logic [31:0] col);
		layout_result_t quad, done;
		int page_cell, advance;
		done = '{default: '0};
		done.kind = RK_DONE;
		done.last = 1'b1;
		quad = '{default: '0};
		if (kind == KIND_START) begin
			org_x = int'($signed(sx));
			pen_x = org_x;
			pen_y = int'($signed(sy));
			limit_left = int'(lim);
			limit_on = (lim != 16'd0);
			msg_color = col;
			drawn = 0;
			swallow_next = 1'b0;
			in_message = 1'b1;
			return;
		end
		if (!in_message)
			return;
		if (swallow_next) begin
			swallow_next = 1'b0;
			return;
		end
		if (code == CODE_NEWLINE) begin
			pen_x = org_x;
			pen_y = pen_step(pen_y, scale_px(30, sc_line));
		end else if (code == CODE_SPACE) begin
			pen_x = pen_step(pen_x, scale_px(14, sc_x));
			if (spaces_count && spend_limit()) begin
				owed_results.push_back(done);
				in_message = 1'b0;
			end
		end else if (code == CODE_SWALLOW_A || code == CODE_SWALLOW_B) begin
			swallow_next = 1'b1;
		end else if (code == CODE_GAP) begin
			pen_x = pen_step(pen_x, scale_px(28, sc_x));
		end else if (code >= CODE_IGNORE_LO && code <= IGNORE_HI) begin
			// Reserved codes leave everything as it is.
		end else if (code == CODE_END) begin
			done.count = drawn[15:0];
			owed_results.push_back(done);
			in_message = 1'b0;
		end else begin
			page_cell = int'(code) % CELLS_PER_PAGE;
			quad.kind = RK_GLYPH;
			quad.pos_x = pen_x[15:0];
			quad.pos_y = pen_y[15:0];
			quad.page = 8'(int'(code) / CELLS_PER_PAGE);
			quad.u = 8'((page_cell % CELLS_PER_ROW) * CELL_PIXELS);
			quad.v = 8'((page_cell / CELLS_PER_ROW) * CELL_PIXELS);
			if (direct_color)
				quad.argb = msg_color;
			else
				quad.argb = (msg_color < 32'd5) ? TINTS[msg_color[2:0]] : TINTS[0];
			quad.quad_w = 16'(scale_px(28, sc_x));
			quad.quad_h = 16'(scale_px(28, sc_y));
			if (drawn < 65535)
				drawn++;
			quad.count = drawn[15:0];
			quad.last = 1'b1;
			advance = (int'(code) < FONT_TABLE_SIZE) ? GLYPH_ADVANCE[code] : 0;
			pen_x = pen_step(pen_x, scale_px(advance, sc_x));
			if (spend_limit()) begin
				quad.last = 1'b0;
				owed_results.push_back(quad);
				owed_results.push_back(done);
				in_message = 1'b0;
			end else begin
				owed_results.push_back(quad);
			end
		end
	endtask

	task automatic check_result();
		layout_result_t want;
		if (owed_results.size() == 0) begin
			note_failure($sformatf("result of kind %0d with nothing owed", m_tuser));
			return;
		end
		want = owed_results.pop_front();
		n_checked++;
		compare_field("result_kind", want.kind, m_tuser);
		compare_field("last", want.last, m_tlast);
		compare_field("pos_x", want.pos_x, m_tdata[15:0]);
		compare_field("pos_y", want.pos_y, m_tdata[31:16]);
		compare_field("tex_page", want.page, m_tdata[39:32]);
		compare_field("tex_u", want.u, m_tdata[47:40]);
		compare_field("tex_v", want.v, m_tdata[55:48]);
		compare_field("argb", want.argb, m_tdata[87:56]);
		compare_field("quad_w", want.quad_w, m_tdata[103:88]);
		compare_field("quad_h", want.quad_h, m_tdata[119:104]);
		compare_field("drawn_count", want.count, m_tdata[135:120]);
		if (want.kind == RK_DONE)
			done_count++;
		else
			glyph_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sc_x = SCALE_ONE;
			sc_y = SCALE_ONE;
			sc_line = SCALE_ONE;
			direct_color = 1'b0;
			spaces_count = 1'b0;
			pen_x = 0;
			pen_y = 0;
			org_x = 0;
			drawn = 0;
			limit_left = 0;
			swallow_next = 1'b0;
			limit_on = 1'b0;
			in_message = 1'b0;
			msg_color = '0;
			n_checked = 0;
			mismatches = 0;
			glyph_count = 0;
			done_count = 0;
			owed_results.delete();
			pending <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SCALE_X:      sc_x = cfg_data;
					REG_SCALE_Y:      sc_y = cfg_data;
					REG_SCALE_LINE:   sc_line = cfg_data;
					REG_COLOR_DIRECT: direct_color = cfg_data[0];
					REG_COUNT_SPACES: spaces_count = cfg_data[0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready)
				check_result();
			if (s_tvalid && s_tready)
				lay_out_request(s_tuser, s_tdata[15:0], s_tdata[31:16], s_tdata[47:32],
					s_tdata[63:48], s_tdata[95:64]);
			pending <= owed_results.size();
		end
	end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Glyph layout testbench
// Drives text messages into the glyph layout block: a directed opening over
// the control codes, pen saturation and the glyph limit, then random messages
// under several register settings and idle mixes, and a long result hold-off.
// A separate checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
	import tcgl_pkg::*;

	// Enough to clear anything in flight in the input and output registers.
	localparam int SETTLE_CYCLES = 6;
	// Receiver hold-off used to fill the block and back-pressure the requests.
	localparam int LONG_HOLD = 300;
	// No correct run goes this long without a request or a result moving.
	localparam int WATCHDOG_LIMIT = 2000;
	// Indexes from here up select no register and must be ignored.
	localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 3'd5;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	// Fields from bit 0 up: code, start_x, start_y, glyph_limit, color.
	logic [S_DATA_W-1:0]  s_tdata = '0;
	// Request kind: start of message or code word.
	logic                 s_tuser = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// Fields from bit 0 up: pos_x, pos_y, tex_page, tex_u, tex_v, argb,
	// quad_w, quad_h, drawn_count.
	logic [M_DATA_W-1:0]  m_tdata;
	// Result kind: glyph quad or message done.
	logic                 m_tuser;
	logic                 m_tlast;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0]          cfg_data = '0;

	int mismatches, pending, glyph_count, done_count;

	// Percent chance per cycle that the sender idles or the receiver stalls.
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	bit long_hold_pending = 1'b0;
	int requests_sent = 0;
	int settings_loaded = 0;

	text_code_stream_glyph_layout dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	tcgl_layout_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tuser     (s_tuser),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tuser     (m_tuser),
		.m_tlast     (m_tlast),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.mismatches  (mismatches),
		.pending     (pending),
		.glyph_count (glyph_count),
		.done_count  (done_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Ends the run when nothing has moved on either stream for too long.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Timeout: no request or result moved for %0d cycles", WATCHDOG_LIMIT);
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// Result side. Each cycle it stalls with the current chance, except when a
	// long hold-off is asked for: then it keeps tready low for the whole hold-off,
	// counted here, while the sender keeps offering requests.
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (long_hold_pending) begin
				long_hold_pending = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD - 1) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// Offers one request and returns at the edge where it is taken. tvalid is
	// left high so that back-to-back requests never drop it in between; idle
	// cycles before the request lower it.
	task automatic send_request(input logic kind, input logic [15:0] code,
			input logic [15:0] sx, input logic [15:0] sy, input logic [15:0] lim,
			input logic [31:0] col);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {col, lim, sy, sx, code};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		requests_sent++;
	endtask

	// Fields a request does not use carry random junk the block must ignore.
	task automatic send_code(input logic [15:0] code);
		send_request(KIND_CODE, code, 16'($urandom), 16'($urandom), 16'($urandom),
			$urandom);
	endtask

	task automatic send_start(input logic [15:0] sx, input logic [15:0] sy,
			input logic [15:0] lim, input logic [31:0] col);
		send_request(KIND_START, 16'($urandom), sx, sy, lim, col);
	endtask

	// Stops the sender and waits until every owed result has come back, then
	// lets a few more cycles pass for requests that produce nothing.
	task automatic settle();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	// Writes all registers while the block is idle. The one-bit modes get
	// random upper bits, which the block has to mask off, and one write goes
	// to an index with no register behind it.
	task automatic load_settings(input logic [15:0] sx, input logic [15:0] sy,
			input logic [15:0] sl, input bit direct, input bit spaces);
		write_register(REG_NONE_LO + 3'($urandom_range(2)), 16'($urandom));
		write_register(REG_SCALE_X, sx);
		write_register(REG_SCALE_Y, sy);
		write_register(REG_SCALE_LINE, sl);
		write_register(REG_COLOR_DIRECT, {15'($urandom), direct});
		write_register(REG_COUNT_SPACES, {15'($urandom), spaces});
		cfg_we <= 1'b0;
		@(posedge clk);
		settings_loaded++;
	endtask

	function automatic logic [15:0] pick_pos();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 16'h7FFF - 16'($urandom_range(255));
		if (r == 1)
			return 16'h8000 + 16'($urandom_range(255));
		if (r < 5)
			return 16'($urandom);
		return 16'($urandom_range(16'h0FFF));
	endfunction

	function automatic logic [15:0] pick_limit();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return 16'd0;
		if (r < 85)
			return 16'($urandom_range(1, 12));
		return 16'($urandom);
	endfunction

	function automatic logic [31:0] pick_color();
		if ($urandom_range(99) < 60)
			return 32'($urandom_range(6));
		return $urandom;
	endfunction

	// Mostly printable glyphs, with every control code but the end code, and
	// the codes right around the reserved range mixed in.
	function automatic logic [15:0] pick_code();
		int r;
		r = $urandom_range(99);
		if (r < 45)
			return 16'($urandom_range(FONT_TABLE_SIZE - 1));
		if (r < 55)
			return 16'($urandom_range(FONT_TABLE_SIZE, 16'hFDFF));
		if (r < 60)
			return 16'($urandom);
		if (r < 68)
			return CODE_SPACE;
		if (r < 73)
			return CODE_NEWLINE;
		if (r < 77)
			return CODE_GAP;
		if (r < 81)
			return $urandom_range(1) ? CODE_SWALLOW_A : CODE_SWALLOW_B;
		if (r < 85)
			return CODE_IGNORE_LO + 16'($urandom_range(15));
		if (r < 88)
			return $urandom_range(1) ? 16'($urandom_range(16'hFE10, 16'hFEFF))
				: 16'($urandom_range(16'hFF05, 16'hFFFE));
		return 16'($urandom_range(FONT_TABLE_SIZE - 1));
	endfunction

	// One well-formed message with random content; most end with the end
	// code, the rest are cut short by the next start. Now and then a stray
	// code follows, which lands on an idle block when the message ended.
	task automatic run_message(output int n);
		int len;
		send_start(pick_pos(), pick_pos(), pick_limit(), pick_color());
		len = $urandom_range(1, 24);
		repeat (len) send_code(pick_code());
		n = len + 1;
		if ($urandom_range(99) < 75) begin
			send_code(CODE_END);
			n++;
		end
		if ($urandom_range(99) < 8)
			send_code(pick_code());
	endtask

	task automatic run_phase(input int target, input int s_idle, input int r_stall);
		int sent, n;
		send_idle_pct = s_idle;
		recv_stall_pct = r_stall;
		sent = 0;
		while (sent < target) begin
			run_message(n);
			sent += n;
		end
		settle();
	endtask

	initial begin : stimulus
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed opening at the reset register values, no idling.
		// A code word before any start must be dropped.
		send_code(16'd33);
		send_start(16'd0, 16'd0, 16'd0, 32'd1);
		send_code(16'd0);
		send_code(16'(FONT_TABLE_SIZE - 1));
		send_code(16'(FONT_TABLE_SIZE));     // first code without a font width
		send_code(16'hFFFE);                 // highest texture page
		send_code(CODE_IGNORE_LO - 16'd1);
		send_code(CODE_NEWLINE);
		send_code(CODE_SPACE);
		send_code(CODE_GAP);
		send_code(CODE_SWALLOW_A);
		send_code(CODE_END);                 // swallowed, message goes on
		send_code(CODE_SWALLOW_B);
		send_code(CODE_NEWLINE);             // swallowed as well
		send_code(CODE_IGNORE_LO);
		send_code(CODE_IGNORE_LO + 16'd15);
		send_code(CODE_IGNORE_LO + 16'd16);  // just past the reserved range: a glyph
		send_code(CODE_END);
		// Pen near the top of its range saturates on both axes, an out of range
		// palette index gives white, and the second glyph uses up the limit.
		send_start(16'h7FF0, 16'h7FF0, 16'd2, 32'd7);
		send_code(16'd0);
		send_code(CODE_NEWLINE);
		send_code(16'd10);
		send_code(16'd5);                    // block is idle again
		// A restart while a swallow is pending clears the swallow.
		send_start(16'h8000, 16'h8000, 16'd0, 32'hFFFFFFFF);
		send_code(CODE_SWALLOW_A);
		send_start(16'h8000, 16'h8000, 16'd0, 32'd0);
		send_code(16'd5);
		send_code(CODE_END);
		settle();

		// Random messages under a series of register settings and idle mixes.
		load_settings(SCALE_ONE, SCALE_ONE, SCALE_ONE, 1'b0, 1'b1);
		run_phase(250, 0, 0);
		load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1);
		run_phase(250, 58, 0);
		load_settings(16'h0000, 16'h0000, 16'h0000, 1'b0, 1'b0);
		run_phase(250, 0, 58);
		load_settings(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
			1'($urandom));
		run_phase(250, 7, 7);

		// Long receiver hold-off with the sender pushing glyphs flat out, so the
		// block fills and back-pressures its request side.
		load_settings(16'h1800, 16'h0C00, 16'h2000, 1'b1, 1'b0);
		send_idle_pct = 0;
		recv_stall_pct = 0;
		send_start(16'd0, 16'd0, 16'd0, 32'h80402010);
		long_hold_pending = 1'b1;
		repeat (48) send_code(16'($urandom_range(FONT_TABLE_SIZE - 1)));
		send_code(CODE_END);
		run_phase(200, 0, 0);

		$display("Covered %0d requests over %0d register settings and all idle mixes.",
			requests_sent, settings_loaded);
		$display("Checked %0d glyph quads and %0d done results, %0d mismatches.",
			glyph_count, done_count, mismatches);
		if (mismatches == 0 && pending == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ filelist.f @@
rtl/core/tcgl_pkg.sv
rtl/core/tcgl_cell_map.sv
rtl/core/text_code_stream_glyph_layout.sv
tb/tcgl_layout_checker.sv
tb/tb.sv
